[rtl/ppphd_pkg.sv]
// ----------------------------------------------------------------------------
// ppphd_pkg
// Shared types, constants and the FCS-16 byte update for the PPP async
// HDLC deframer.
// ----------------------------------------------------------------------------
package ppphd_pkg;

  // framing bytes
  localparam logic [7:0]  FLAG_BYTE      = 8'h7E;
  localparam logic [7:0]  ESC_BYTE       = 8'h7D;
  localparam logic [7:0]  ESC_XOR        = 8'h20;
  localparam logic [15:0] FCS_INIT       = 16'hFFFF;
  localparam logic [15:0] FCS_GOOD       = 16'hF0B8;
  localparam logic [15:0] PPP_FCS_POLY   = 16'h8408;
  localparam logic [15:0] ADDR_CTRL      = 16'hFF03;
  localparam logic [7:0]  PROTO_ODD_MASK = 8'h01;
  localparam int          FCS_BYTES      = 2;

  // header parse window
  localparam int HEADER_WINDOW = 4;
  localparam int WIN_AW        = $clog2(HEADER_WINDOW);

  // result queue depth default
  localparam int RESQ_DEPTH = 4;

  // register reset values
  localparam logic [15:0] MAX_FRAME_RST = 16'd1502;
  localparam logic        STRIP_RST     = 1'b1;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_FRAME_BYTES = 1'b0,
    REG_STRIP_PROTOCOL  = 1'b1
  } cfg_reg_t;

  // result kinds and end record status codes
  localparam logic       KIND_PAYLOAD = 1'b0;
  localparam logic       KIND_END     = 1'b1;
  localparam logic [1:0] STAT_GOOD     = 2'd0;
  localparam logic [1:0] STAT_BAD_FCS  = 2'd1;
  localparam logic [1:0] STAT_SHORT    = 2'd2;
  localparam logic [1:0] STAT_OVERFLOW = 2'd3;

  typedef struct packed {
    logic [7:0]  rx_byte;
    logic [31:0] tag;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic [1:0]  frame_status;
    logic [15:0] protocol;
    logic [15:0] payload_length;
    logic [31:0] frame_tag;
    logic        last;
  } out_item_t;

  // up to two results per processed item
  typedef struct packed {
    logic [1:0] n;
    out_item_t  r0;
    out_item_t  r1;
  } push_t;

  // reflected crc-16, one byte
  function automatic logic [15:0] fcs16_byte(logic [15:0] fcs, logic [7:0] d);
    logic [15:0] f;
    f = fcs ^ {8'h00, d};
    for (int b = 0; b < 8; b++) begin
      f = f[0] ? ((f >> 1) ^ PPP_FCS_POLY) : (f >> 1);
    end
    return f;
  endfunction

endpackage

[rtl/ppp_async_hdlc_deframer_top.sv]
// ----------------------------------------------------------------------------
// ppp_async_hdlc_deframer_top
// PPP async HDLC-like deframer with FCS-16 check and cut-through payload.
// ----------------------------------------------------------------------------
// in_*  : one raw received byte and a caller tag per transaction
// out_* : payload bytes (kind 0) and one end record per frame (kind 1);
//         last marks the final result caused by one input byte
// cfg_* : register writes, index 0 max_frame_bytes, index 1 strip_protocol;
//         cfg_ready is always high; writes are to be made by the user while
//         the block is idle; the block itself does not enforce this
// path: input register, then result queue, then out_*
// throughput: one byte per cycle while the queue has room for two results;
//          the only two-result byte completes the header without stripping
//          and without address/control field; the result queue drains it
// stall: when out_ready is low the queue fills, the input register holds
//          its byte and in_ready drops; nothing is lost
// reset: link hunts for the first flag, registers return to 1502 and 1,
//          queue and input register empty
// ----------------------------------------------------------------------------
module ppp_async_hdlc_deframer_top
  import ppphd_pkg::*;
#(
  parameter int RESQ_D = RESQ_DEPTH
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  // result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  // configuration channel
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // input register stage
  logic        in_v_r, in_v_nxt;
  in_item_t    in_d_r;
  logic        space;
  logic        fire;

  // configuration registers
  logic [15:0] max_r, max_nxt;
  logic        strip_r, strip_nxt;

  push_t       push;

  // the core works the held byte when the queue can absorb two results
  assign fire      = in_v_r && space;
  assign in_ready  = !in_v_r || fire;
  assign cfg_ready = 1'b1;

  always_comb begin
    in_v_nxt = in_v_r;
    if (fire) begin
      in_v_nxt = 1'b0;
    end
    if (in_valid && in_ready) begin
      in_v_nxt = 1'b1;
    end
  end

  always_comb begin
    max_nxt   = max_r;
    strip_nxt = strip_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MAX_FRAME_BYTES: max_nxt   = cfg_data[15:0];
        REG_STRIP_PROTOCOL:  strip_nxt = cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      max_r   <= MAX_FRAME_RST;
      strip_r <= STRIP_RST;
    end else begin
      in_v_r  <= in_v_nxt;
      max_r   <= max_nxt;
      strip_r <= strip_nxt;
    end
  end

  // payload register, loaded on each accepted transaction
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_d_r <= in_data;
    end
  end

  ppphd_core u_core (
    .clk               (clk),
    .rst_n             (rst_n),
    .fire_i            (fire),
    .item_i            (in_d_r),
    .max_frame_bytes_i (max_r),
    .strip_protocol_i  (strip_r),
    .push_o            (push)
  );

  ppphd_resq #(
    .DEPTH (RESQ_D)
  ) u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_i    (push),
    .space_o   (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

[rtl/ppphd_core.sv]
// ----------------------------------------------------------------------------
// ppphd_core
// Deframer state: flag hunt, unescape, FCS, header parse and two-byte
// hold-back window. Produces up to two results per processed byte.
// ----------------------------------------------------------------------------
module ppphd_core
  import ppphd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire_i,
  input  in_item_t    item_i,
  input  logic [15:0] max_frame_bytes_i,
  input  logic        strip_protocol_i,
  output push_t       push_o
);

  typedef enum logic [1:0] {
    MODE_HUNT,
    MODE_SYNC,
    MODE_FRAME
  } mode_t;

  mode_t       mode_r, mode_nxt;
  logic        esc_r, esc_nxt;
  logic [15:0] fcs_r, fcs_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic        hdr_r, hdr_nxt;
  logic [15:0] proto_r, proto_nxt;
  logic        ovf_r, ovf_nxt;
  logic [7:0]  win_r   [HEADER_WINDOW];
  logic [7:0]  win_nxt [HEADER_WINDOW];

  logic [7:0]  c;
  logic [7:0]  dat;
  logic [7:0]  w [HEADER_WINDOW];
  logic        acf;
  logic [7:0]  pb0, pb1;
  logic        short_pf;
  logic [2:0]  hl;
  logic [15:0] delivered;
  logic [1:0]  status;
  push_t       push;

  function automatic out_item_t pay(logic [7:0] d);
    out_item_t r;
    r = '0;
    r.kind         = KIND_PAYLOAD;
    r.payload_byte = d;
    return r;
  endfunction

  always_comb begin
    mode_nxt  = mode_r;
    esc_nxt   = esc_r;
    fcs_nxt   = fcs_r;
    cnt_nxt   = cnt_r;
    hdr_nxt   = hdr_r;
    proto_nxt = proto_r;
    ovf_nxt   = ovf_r;
    win_nxt   = win_r;
    push      = '0;

    c   = item_i.rx_byte;
    dat = esc_r ? (c ^ ESC_XOR) : c;

    // header window as it stands once the fourth byte lands
    w = win_r;
    w[HEADER_WINDOW-1] = dat;
    acf      = ({w[0], w[1]} == ADDR_CTRL);
    pb0      = acf ? w[2] : w[0];
    pb1      = acf ? w[3] : w[1];
    short_pf = ((pb0 & PROTO_ODD_MASK) != 8'h00);
    if (strip_protocol_i) begin
      hl = {1'b0, acf, 1'b0} + (short_pf ? 3'd1 : 3'd2);
    end else begin
      hl = {1'b0, acf, 1'b0};
    end

    delivered = '0;
    if (hdr_r && cnt_r >= 16'(FCS_BYTES)) begin
      delivered = cnt_r - 16'(FCS_BYTES);
    end
    if (ovf_r) begin
      status = STAT_OVERFLOW;
    end else if (!hdr_r || cnt_r < 16'(FCS_BYTES)) begin
      status = STAT_SHORT;
    end else if (fcs_r != FCS_GOOD) begin
      status = STAT_BAD_FCS;
    end else begin
      status = STAT_GOOD;
    end

    if (fire_i) begin
      if (mode_r == MODE_HUNT) begin
        if (c == FLAG_BYTE) begin
          mode_nxt = MODE_SYNC;
        end
      end else if (c == FLAG_BYTE) begin
        if (mode_r == MODE_FRAME) begin
          // closing flag: end record and frame clear
          push.n                 = 2'd1;
          push.r0.kind           = KIND_END;
          push.r0.frame_status   = status;
          push.r0.protocol       = hdr_r ? proto_r : 16'h0000;
          push.r0.payload_length = delivered;
          push.r0.frame_tag      = item_i.tag;
          mode_nxt  = MODE_SYNC;
          esc_nxt   = 1'b0;
          fcs_nxt   = FCS_INIT;
          cnt_nxt   = '0;
          hdr_nxt   = 1'b0;
          proto_nxt = '0;
          ovf_nxt   = 1'b0;
        end
      end else begin
        mode_nxt = MODE_FRAME;
        if (c == ESC_BYTE && !esc_r) begin
          esc_nxt = 1'b1;
        end else begin
          esc_nxt = 1'b0;
          if (cnt_r >= max_frame_bytes_i) begin
            ovf_nxt = 1'b1;
          end else begin
            fcs_nxt = fcs16_byte(fcs_r, dat);
            if (!hdr_r) begin
              win_nxt[cnt_r[WIN_AW-1:0]] = dat;
              cnt_nxt = cnt_r + 16'd1;
              if (cnt_r == 16'(HEADER_WINDOW - 1)) begin
                // header parse
                hdr_nxt   = 1'b1;
                proto_nxt = short_pf ? {8'h00, pb0} : {pb0, pb1};
                cnt_nxt   = 16'(HEADER_WINDOW) - 16'(hl);
                unique case (hl)
                  3'd0: begin
                    push.n  = 2'd2;
                    push.r0 = pay(w[0]);
                    push.r1 = pay(w[1]);
                  end
                  3'd1: begin
                    push.n  = 2'd1;
                    push.r0 = pay(w[1]);
                  end
                  default: push.n = 2'd0;
                endcase
                if (hl <= 3'd2) begin
                  win_nxt[0] = w[2];
                  win_nxt[1] = w[3];
                end else if (hl == 3'd3) begin
                  win_nxt[0] = w[3];
                end
              end
            end else begin
              if (cnt_r >= 16'(FCS_BYTES)) begin
                push.n     = 2'd1;
                push.r0    = pay(win_r[0]);
                win_nxt[0] = win_r[1];
                win_nxt[1] = dat;
              end else begin
                win_nxt[cnt_r[WIN_AW-1:0]] = dat;
              end
              cnt_nxt = cnt_r + 16'd1;
            end
          end
        end
      end
    end

    if (push.n == 2'd1) begin
      push.r0.last = 1'b1;
    end else if (push.n == 2'd2) begin
      push.r1.last = 1'b1;
    end
  end

  assign push_o = push;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_HUNT;
      esc_r   <= 1'b0;
      fcs_r   <= FCS_INIT;
      cnt_r   <= '0;
      hdr_r   <= 1'b0;
      proto_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      esc_r   <= esc_nxt;
      fcs_r   <= fcs_nxt;
      cnt_r   <= cnt_nxt;
      hdr_r   <= hdr_nxt;
      proto_r <= proto_nxt;
      ovf_r   <= ovf_nxt;
      win_r   <= win_nxt;
    end
  end

  // an end record leaves the frame state cleared and the link in sync
  a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0 && push.r0.kind == KIND_END)
      |=> (mode_r == MODE_SYNC && cnt_r == 16'd0 && !hdr_r && !ovf_r))
    else $error("frame state not cleared after end record");

endmodule

[rtl/ppphd_resq.sv]
// ----------------------------------------------------------------------------
// ppphd_resq
// Result queue: takes up to two results a cycle, hands one a cycle to the
// output channel while out_ready is high.
// ----------------------------------------------------------------------------
module ppphd_resq
  import ppphd_pkg::*;
#(
  parameter int DEPTH = RESQ_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  input  push_t     push_i,
  output logic      space_o,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  out_item_t       mem_r [DEPTH];
  logic [AW-1:0]   wr_r, wr_nxt, wr_p1;
  logic [AW-1:0]   rd_r, rd_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic            pop;

  assign out_valid = (count_r != '0);
  assign out_data  = mem_r[rd_r];
  assign pop       = out_valid && out_ready;
  // room for the worst case of two results
  assign space_o   = (count_r <= CW'(DEPTH - 2));
  assign wr_p1     = wr_r + AW'(1);

  always_comb begin
    wr_nxt    = wr_r + AW'(push_i.n);
    rd_nxt    = pop ? (rd_r + AW'(1)) : rd_r;
    count_nxt = count_r + CW'(push_i.n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_i.n != 2'd0) begin
      mem_r[wr_r] <= push_i.r0;
    end
    if (push_i.n == 2'd2) begin
      mem_r[wr_p1] <= push_i.r1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      wr_r    <= wr_nxt;
      rd_r    <= rd_nxt;
      count_r <= count_nxt;
    end
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push_i.n != 2'd0 |-> (int'(count_r) + int'(push_i.n) <= DEPTH))
    else $error("result queue overrun");

  a_pair_last: assert property (@(posedge clk) disable iff (!rst_n)
    push_i.n == 2'd2 |-> (push_i.r1.last && !push_i.r0.last))
    else $error("last flag misplaced in result pair");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> (count_r == '0 && !out_valid))
    else $error("result queue not empty after reset");

endmodule
